[src/ax25ahp_pkg.sv]
// Package for the AX.25 address header parser.
// Holds the word types, parse state, status codes and constants shared by all files.
// No dependencies.
`default_nettype none

package ax25ahp_pkg;

    localparam int ADDRESS_BYTES = 7;
    localparam int POS_W         = 3;
    localparam int COUNT_W       = 4;
    localparam logic [COUNT_W-1:0] MAX_DIGIS = COUNT_W'(8);
    localparam logic [POS_W-1:0]   SSID_POS  = POS_W'(ADDRESS_BYTES - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEST,
        PH_SRC,
        PH_DIGI
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_TOOMANY
    } status_t;

    typedef enum logic [1:0] {
        CR_UNKNOWN,
        CR_COMMAND,
        CR_RESPONSE
    } cmd_resp_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_last;
    } byte_word_t;

    typedef struct packed {
        status_t            status;
        cmd_resp_t          command_response;
        logic [COUNT_W-1:0] digi_total;
        logic [COUNT_W-1:0] repeated_total;
        logic [COUNT_W-1:0] address_total;
    } hdr_word_t;

    typedef struct packed {
        logic [POS_W-1:0]   byte_position;
        phase_t             parse_phase;
        logic               dest_c_bit;
        cmd_resp_t          cmd_resp_held;
        logic [COUNT_W-1:0] digi_counter;
        logic [COUNT_W-1:0] repeated_counter;
    } parse_state_t;

endpackage

`default_nettype wire

[src/ax25ahp_decode.sv]
// Per-byte decode step of the AX.25 address header parser.
// Computes the next parse state and the optional header result from one byte.
// Depends on ax25ahp_pkg.
`default_nettype none

module ax25ahp_decode (
    input  wire ax25ahp_pkg::parse_state_t st,
    input  wire ax25ahp_pkg::byte_word_t   word,
    output ax25ahp_pkg::parse_state_t      st_next,
    output logic                           emit,
    output ax25ahp_pkg::hdr_word_t         result
);

    always_comb
    begin
        ax25ahp_pkg::parse_state_t s;
        ax25ahp_pkg::status_t      status;
        logic                      ssid;
        logic                      cbit;
        logic                      ebit;

        cbit   = word.data_byte[7];
        ebit   = word.data_byte[0];
        emit   = 1'b0;
        status = ax25ahp_pkg::ST_OK;
        s      = st;

        if (word.frame_start)
        begin
            s.byte_position    = '0;
            s.dest_c_bit       = 1'b0;
            s.cmd_resp_held    = ax25ahp_pkg::CR_UNKNOWN;
            s.digi_counter     = '0;
            s.repeated_counter = '0;
            s.parse_phase      = ax25ahp_pkg::PH_DEST;
        end

        ssid = 1'b0;
        if (s.parse_phase != ax25ahp_pkg::PH_IDLE)
        begin
            ssid = (s.byte_position >= ax25ahp_pkg::SSID_POS);
            if (ssid)
            begin
                s.byte_position = '0;
            end
            else
            begin
                s.byte_position = s.byte_position + ax25ahp_pkg::POS_W'(1);
            end

            if (ssid)
            begin
                case (s.parse_phase)
                    ax25ahp_pkg::PH_DEST:
                    begin
                        s.dest_c_bit  = cbit;
                        s.parse_phase = ax25ahp_pkg::PH_SRC;
                    end
                    ax25ahp_pkg::PH_SRC:
                    begin
                        if (cbit == s.dest_c_bit)
                        begin
                            s.cmd_resp_held = ax25ahp_pkg::CR_UNKNOWN;
                        end
                        else if (cbit)
                        begin
                            s.cmd_resp_held = ax25ahp_pkg::CR_RESPONSE;
                        end
                        else
                        begin
                            s.cmd_resp_held = ax25ahp_pkg::CR_COMMAND;
                        end
                        if (ebit)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            s.parse_phase = ax25ahp_pkg::PH_DIGI;
                        end
                    end
                    default:
                    begin
                        s.digi_counter = s.digi_counter + ax25ahp_pkg::COUNT_W'(1);
                        if (cbit)
                        begin
                            s.repeated_counter = s.repeated_counter
                                               + ax25ahp_pkg::COUNT_W'(1);
                        end
                        if (ebit)
                        begin
                            emit = 1'b1;
                        end
                        else if (s.digi_counter >= ax25ahp_pkg::MAX_DIGIS)
                        begin
                            emit   = 1'b1;
                            status = ax25ahp_pkg::ST_TOOMANY;
                        end
                    end
                endcase
            end

            if (!emit && word.frame_last)
            begin
                emit   = 1'b1;
                status = ax25ahp_pkg::ST_TRUNC;
            end
        end

        result.status           = status;
        result.command_response = s.cmd_resp_held;
        result.digi_total       = s.digi_counter;
        result.repeated_total   = s.repeated_counter;
        result.address_total    = (status == ax25ahp_pkg::ST_OK)
                                ? s.digi_counter + ax25ahp_pkg::COUNT_W'(2) : '0;

        if (emit)
        begin
            s.parse_phase = ax25ahp_pkg::PH_IDLE;
        end
        st_next = s;
    end

endmodule

`default_nettype wire

[src/ax25ahp_unit.sv]
// Top level of the AX.25 address header parser.
// Input register, decode step and result register; instantiates ax25ahp_decode.
// Depends on ax25ahp_pkg.
//
// Channel    Handshake              Word
// byte       byte_valid/byte_stall  byte_word (data_byte, frame_start, frame_last)
// hdr        hdr_valid/hdr_stall    hdr_word (status, counts, command_response)
//
// One byte is accepted per cycle while byte_stall is low.
// The input register feeds the decode step, whose result lands in the output register.
// A stalled result holds the output register and, behind it, the input register.
// Reset clears the parse state to idle and empties both registers.
`default_nettype none

module ax25_address_header_parser_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    output logic                        byte_stall,
    input  wire ax25ahp_pkg::byte_word_t byte_word,
    output logic                        hdr_valid,
    input  wire logic                   hdr_stall,
    output ax25ahp_pkg::hdr_word_t      hdr_word
);

    logic                      in_valid_reg;
    ax25ahp_pkg::byte_word_t   in_word_reg;
    ax25ahp_pkg::parse_state_t state_reg;
    ax25ahp_pkg::parse_state_t state_next;
    logic                      out_valid_reg;
    ax25ahp_pkg::hdr_word_t    out_word_reg;
    logic                      emit;
    ax25ahp_pkg::hdr_word_t    result;
    logic                      out_free;
    logic                      advance;

    ax25ahp_decode u_decode (
        .st      (state_reg),
        .word    (in_word_reg),
        .st_next (state_next),
        .emit    (emit),
        .result  (result)
    );

    assign out_free   = !out_valid_reg || !hdr_stall;
    assign advance    = in_valid_reg && out_free;
    assign byte_stall = in_valid_reg && !out_free;
    assign hdr_valid  = out_valid_reg;
    assign hdr_word   = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{byte_position: '0, parse_phase: ax25ahp_pkg::PH_IDLE,
                               dest_c_bit: 1'b0, cmd_resp_held: ax25ahp_pkg::CR_UNKNOWN,
                               digi_counter: '0, repeated_counter: '0};
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_word_reg <= byte_word;
        end
        if (advance && emit)
        begin
            out_word_reg <= result;
        end
    end

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.status == ax25ahp_pkg::ST_OK)
        |-> (out_word_reg.address_total
             == out_word_reg.digi_total + ax25ahp_pkg::COUNT_W'(2)))
        else $error("successful header with inconsistent address count");

    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.status != ax25ahp_pkg::ST_OK)
        |-> (out_word_reg.address_total == '0))
        else $error("failed header with nonzero address count");

    a_rep_le_digi: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.repeated_counter <= state_reg.digi_counter)
        else $error("repeated count exceeds digipeater count");

    a_digi_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digi_counter <= ax25ahp_pkg::MAX_DIGIS)
        else $error("digipeater count above limit");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |=> in_valid_reg && $stable(in_word_reg))
        else $error("input register changed while stalled");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for ax25_address_header_parser_unit.
// Drives frame bytes, predicts each header word, and checks every result field.
// Depends on ax25ahp_pkg and the unit under test.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TARGET_BYTES = 1050;

    class header_scoreboard;
        logic [ax25ahp_pkg::POS_W-1:0] pos = '0;
        ax25ahp_pkg::phase_t phase = ax25ahp_pkg::PH_IDLE;
        logic dest_c = 1'b0;
        ax25ahp_pkg::cmd_resp_t cr = ax25ahp_pkg::CR_UNKNOWN;
        logic [ax25ahp_pkg::COUNT_W-1:0] digis = '0;
        logic [ax25ahp_pkg::COUNT_W-1:0] reps = '0;
        ax25ahp_pkg::hdr_word_t pending_headers[$];
        int headers_due = 0;
        int headers_seen = 0;
        int mismatches = 0;
        int status_seen[3] = '{0, 0, 0};

        function void close_header(ax25ahp_pkg::status_t st);
            ax25ahp_pkg::hdr_word_t w;
            w.status = st;
            w.command_response = cr;
            w.digi_total = digis;
            w.repeated_total = reps;
            w.address_total = (st == ax25ahp_pkg::ST_OK) ? digis + 4'd2 : '0;
            pending_headers.push_back(w);
            headers_due++;
            phase = ax25ahp_pkg::PH_IDLE;
        endfunction

        function void take_byte(ax25ahp_pkg::byte_word_t w);
            logic ssid;
            logic cbit;
            logic ebit;
            cbit = w.data_byte[7];
            ebit = w.data_byte[0];
            if (w.frame_start)
            begin
                pos = '0;
                dest_c = 1'b0;
                cr = ax25ahp_pkg::CR_UNKNOWN;
                digis = '0;
                reps = '0;
                phase = ax25ahp_pkg::PH_DEST;
            end
            if (phase == ax25ahp_pkg::PH_IDLE)
                return;
            ssid = (pos >= ax25ahp_pkg::SSID_POS);
            pos = ssid ? '0 : pos + 3'd1;
            if (ssid)
            begin
                case (phase)
                    ax25ahp_pkg::PH_DEST:
                    begin
                        dest_c = cbit;
                        phase = ax25ahp_pkg::PH_SRC;
                    end
                    ax25ahp_pkg::PH_SRC:
                    begin
                        cr = (cbit == dest_c) ? ax25ahp_pkg::CR_UNKNOWN
                           : (cbit ? ax25ahp_pkg::CR_RESPONSE : ax25ahp_pkg::CR_COMMAND);
                        if (ebit)
                        begin
                            close_header(ax25ahp_pkg::ST_OK);
                            return;
                        end
                        phase = ax25ahp_pkg::PH_DIGI;
                    end
                    default:
                    begin
                        digis = digis + 4'd1;
                        if (cbit)
                            reps = reps + 4'd1;
                        if (ebit)
                        begin
                            close_header(ax25ahp_pkg::ST_OK);
                            return;
                        end
                        if (digis >= ax25ahp_pkg::MAX_DIGIS)
                        begin
                            close_header(ax25ahp_pkg::ST_TOOMANY);
                            return;
                        end
                    end
                endcase
            end
            if (w.frame_last)
                close_header(ax25ahp_pkg::ST_TRUNC);
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_header(ax25ahp_pkg::hdr_word_t got);
            ax25ahp_pkg::hdr_word_t want;
            if (pending_headers.size() == 0)
            begin
                $error("header word with none expected: %p", got);
                mismatches++;
                return;
            end
            want = pending_headers.pop_front();
            headers_seen++;
            status_seen[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("command_response", want.command_response, got.command_response);
            compare_field("digi_total", want.digi_total, got.digi_total);
            compare_field("repeated_total", want.repeated_total, got.repeated_total);
            compare_field("address_total", want.address_total, got.address_total);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    ax25ahp_pkg::byte_word_t byte_word = '0;
    logic hdr_valid;
    logic hdr_stall = 1'b0;
    ax25ahp_pkg::hdr_word_t hdr_word;

    header_scoreboard sb = new();
    ax25ahp_pkg::byte_word_t frame_bytes[$];
    bit gaps_on = 1'b1;
    bit hold_off_req = 1'b0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int idle_cycles = 0;

    ax25_address_header_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_word (byte_word),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_word  (hdr_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic ax25ahp_pkg::byte_word_t word_of(logic [7:0] data, logic start,
                                                         logic last);
        ax25ahp_pkg::byte_word_t w;
        w.data_byte = data;
        w.frame_start = start;
        w.frame_last = last;
        return w;
    endfunction

    task automatic send_byte(input ax25ahp_pkg::byte_word_t w);
        if (gaps_on && $urandom_range(99) < 10)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word <= w;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sb.take_byte(w);
        bytes_sent++;
    endtask

    task automatic wait_for_headers();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_headers.size() != 0);
    endtask

    function automatic void add_address(logic c_bit, logic e_bit);
        ax25ahp_pkg::byte_word_t w;
        for (int i = 0; i < ax25ahp_pkg::ADDRESS_BYTES; i++)
        begin
            w = word_of(8'($urandom_range(255)), 1'b0, 1'b0);
            if (i == ax25ahp_pkg::ADDRESS_BYTES - 1)
            begin
                w.data_byte[7] = c_bit;
                w.data_byte[0] = e_bit;
            end
            frame_bytes.push_back(w);
        end
    endfunction

    task automatic send_frame(input int digi_count, input bit ended, input int cut,
                              input int tail, input bit marked);
        frame_bytes.delete();
        add_address(1'($urandom_range(1)), 1'($urandom_range(1)));
        add_address(1'($urandom_range(1)), ended && digi_count == 0);
        for (int d = 1; d <= digi_count; d++)
            add_address(1'($urandom_range(1)), ended && d == digi_count);
        repeat (tail)
            frame_bytes.push_back(word_of(8'($urandom_range(255)), 1'b0,
                                          $urandom_range(7) == 0));
        if (cut > 0)
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        frame_bytes[0].frame_start = 1'b1;
        if (marked)
            frame_bytes[frame_bytes.size() - 1].frame_last = 1'b1;
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frames_sent++;
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_byte(word_of(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1))));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hdr_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hdr_stall <= 1'b0;
            end
            else
            begin
                hdr_stall <= gaps_on && ($urandom_range(99) < 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (hdr_valid && !hdr_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (hdr_valid && !hdr_stall)
                sb.check_header(hdr_word);
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Watchdog expired after %0d cycles without a handshake.", WATCHDOG_LIMIT);
        $display("[ax25_address_header_parser_unit] ERROR");
        $finish;
    end

    initial
    begin
        int kind;
        int digi_count;
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes outside a frame are ignored, frame_last included.
        send_byte(word_of(8'h00, 1'b0, 1'b1));
        send_byte(word_of(8'hFF, 1'b0, 1'b0));
        // A frame that starts and ends on one byte is truncated.
        send_byte(word_of(8'hFF, 1'b1, 1'b1));
        // An abandoned frame, restarted mid-address by a new start.
        send_byte(word_of(8'h00, 1'b1, 1'b0));
        send_byte(word_of(8'h55, 1'b0, 1'b0));
        send_byte(word_of(8'hAA, 1'b0, 1'b0));
        // Command frame whose header ends on the last byte; the destination E bit is set.
        for (int i = 0; i < 2 * ax25ahp_pkg::ADDRESS_BYTES; i++)
            send_byte(word_of((i < 6) ? 8'hFF : (i == 6) ? 8'h81 : (i < 13) ? 8'h00 : 8'h01,
                              i == 0, i == 2 * ax25ahp_pkg::ADDRESS_BYTES - 1));
        wait_for_headers();

        while (bytes_sent < TARGET_BYTES)
        begin
            gaps_on = !(frames_sent >= 30 && frames_sent < 45);
            if (frames_sent == 12)
            begin
                hold_off_req = 1'b1;
                repeat (4)
                    send_frame(0, 1'b1, 0, 0, 1'b1);
            end
            if (frames_sent == 22)
                wait_for_headers();
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                send_noise($urandom_range(3, 1));
            end
            else if (kind < 25)
            begin
                digi_count = $urandom_range(3);
                len = 2 * ax25ahp_pkg::ADDRESS_BYTES + ax25ahp_pkg::ADDRESS_BYTES * digi_count;
                send_frame(digi_count, 1'b1, $urandom_range(len - 1, 1), 0, 1'b1);
            end
            else if (kind < 32)
            begin
                digi_count = $urandom_range(3);
                len = 2 * ax25ahp_pkg::ADDRESS_BYTES + ax25ahp_pkg::ADDRESS_BYTES * digi_count;
                send_frame(digi_count, 1'b1, $urandom_range(len - 1, 1), 0, 1'b0);
            end
            else if (kind < 42)
            begin
                send_frame($urandom_range(9, 6), 1'($urandom_range(1)), 0,
                           $urandom_range(4), 1'b1);
            end
            else
            begin
                send_frame($urandom_range(3), $urandom_range(19) != 0, 0,
                           $urandom_range(5), 1'b1);
            end
        end

        wait_for_headers();
        repeat (8) @(posedge clk);
        if (sb.pending_headers.size() != 0)
            $error("%0d header words never arrived", sb.pending_headers.size());
        $display("Sent %0d bytes in %0d frames; checked %0d header words",
                 bytes_sent, frames_sent, sb.headers_seen);
        $display("(%0d ok, %0d truncated, %0d too many digipeaters).",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        if (sb.mismatches == 0 && sb.pending_headers.size() == 0)
            $display("[ax25_address_header_parser_unit] OK");
        else
            $display("[ax25_address_header_parser_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/ax25ahp_pkg.sv
src/ax25ahp_decode.sv
src/ax25ahp_unit.sv
tb/tb_top.sv
